>>> hdl/b2b_pkg.sv
// BLAKE2b shared package: IV, message schedule, widths and the front/back command word.
// No dependencies.
package b2b_pkg;

    localparam int unsigned WordW  = 64;
    localparam int unsigned BlkWds = 16;

    typedef logic [WordW-1:0] t_word;
    typedef logic [3:0]       t_widx;

    typedef struct packed {
        logic   fin;
        logic   [127:0] len;
    } t_cmd;

    function automatic t_word iv_word(input logic [2:0] k);
        case (k)
            3'd0:    iv_word = 64'h6a09e667f3bcc908;
            3'd1:    iv_word = 64'hbb67ae8584caa73b;
            3'd2:    iv_word = 64'h3c6ef372fe94f82b;
            3'd3:    iv_word = 64'ha54ff53a5f1d36f1;
            3'd4:    iv_word = 64'h510e527fade682d1;
            3'd5:    iv_word = 64'h9b05688c2b3e6c1f;
            3'd6:    iv_word = 64'h1f83d9abfb41bd6b;
            default: iv_word = 64'h5be0cd19137e2179;
        endcase
    endfunction

    localparam logic [63:0] ParamWord = 64'h0000_0000_0101_0040;

    function automatic t_widx sigma(input logic [3:0] r, input logic [3:0] j);
        logic [63:0] row;
        begin
            case (r)
                4'd0: row = 64'hfedcba9876543210;
                4'd1: row = 64'h357b20c16df984ae;
                4'd2: row = 64'h491763eadf250c8b;
                4'd3: row = 64'h8f04a562ebcd1397;
                4'd4: row = 64'hd386cb1efa427509;
                4'd5: row = 64'h91ef57d438b0a6c2;
                4'd6: row = 64'hb8293670a4def15c;
                4'd7: row = 64'ha2684f05931ce7bd;
                4'd8: row = 64'h5a417d2c803b9ef6;
                default: row = 64'h0dc3e9bf5167482a;
            endcase
            sigma = row[{j, 2'b00} +: 4];
        end
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

>>> hdl/b2b_front.sv
// BLAKE2b front: packs bytes into 128-byte blocks, keeps the byte counter,
// hands full or final blocks to the back through a one-entry command queue. Uses b2b_pkg.
module b2b_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [63:0]     i_data_word,
    input  logic [3:0]      i_byte_count,
    input  logic            i_end_of_message,
    output logic            o_cmd_valid,
    output b2b_pkg::t_cmd   o_cmd,
    output b2b_pkg::t_word  o_blk [b2b_pkg::BlkWds],
    input  logic            i_cmd_take
);

    b2b_pkg::t_word r_blk [b2b_pkg::BlkWds];
    b2b_pkg::t_word r_qblk [b2b_pkg::BlkWds];
    logic [7:0]     r_fill;
    logic [127:0]   r_len;
    logic           r_qv;
    b2b_pkg::t_cmd  r_qcmd;
    // pending byte item waiting on a full block
    logic           r_busy;
    logic [63:0]    r_data;
    logic [3:0]     r_cnt;
    logic           r_eom;

    logic [3:0] cnt_in;
    logic       q_free;
    logic       need_flush;

    assign q_free      = !r_qv || i_cmd_take;
    assign o_full      = r_busy;
    assign o_cmd_valid = r_qv;
    assign o_cmd       = r_qcmd;
    assign o_blk       = r_qblk;
    assign cnt_in      = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    assign need_flush  = (r_fill == 8'd128) && (r_cnt != 4'd0);

    always_ff @(posedge i_clk) begin
        logic [7:0] f;
        logic       qset;
        qset = 1'b0;
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
            r_qv   <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (i_push) begin
                    r_busy <= 1'b1;
                    r_data <= i_data_word;
                    r_cnt  <= cnt_in;
                    r_eom  <= i_end_of_message;
                end
            end else if (need_flush) begin
                if (q_free) begin
                    qset = 1'b1;
                    r_qcmd.fin <= 1'b0;
                    r_qcmd.len <= r_len + 128'd128;
                    r_len      <= r_len + 128'd128;
                    r_qblk     <= r_blk;
                    r_fill     <= '0;
                end
            end else if (r_cnt != 4'd0) begin
                // append bytes up to the block end
                f = r_fill;
                for (int i = 0; i < 8; i++) begin
                    if (i < 32'(r_cnt) && f < 8'd128) begin
                        r_blk[f[6:3]][{f[2:0], 3'b000} +: 8] <= r_data[i*8 +: 8];
                        f = f + 8'd1;
                    end
                end
                r_cnt  <= r_cnt - 4'(f - r_fill);
                r_data <= r_data >> {(f - r_fill), 3'b000};
                r_fill <= f;
            end else if (r_eom) begin
                if (q_free) begin
                    qset = 1'b1;
                    r_qcmd.fin <= 1'b1;
                    r_qcmd.len <= r_len + 128'(r_fill);
                    for (int w = 0; w < 16; w++)
                        for (int b = 0; b < 8; b++)
                            r_qblk[w][b*8 +: 8] <= (w*8+b < 32'(r_fill)) ?
                                                   r_blk[w][b*8 +: 8] : 8'h00;
                    r_len  <= '0;
                    r_fill <= '0;
                    r_busy <= 1'b0;
                end
            end else begin
                r_busy <= 1'b0;
            end
            if (qset) r_qv <= 1'b1;
            else if (i_cmd_take) r_qv <= 1'b0;
        end
    end

endmodule

>>> hdl/b2b_core.sv
// BLAKE2b back: round-iterative compression, one column or diagonal half-round
// step per cycle, then eight-word digest queue. Uses b2b_pkg.
module b2b_core #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  b2b_pkg::t_cmd   i_cmd,
    input  b2b_pkg::t_word  i_blk [b2b_pkg::BlkWds],
    output logic            o_cmd_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [63:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} t_state;

    localparam int unsigned RW = $clog2(ROUNDS + 1);

    t_state         r_state;
    b2b_pkg::t_word r_h [8];
    b2b_pkg::t_word r_v [16];
    b2b_pkg::t_word r_m [16];
    logic           r_fin;
    logic [RW-1:0]  r_rnd;
    logic [3:0]     r_rmod;
    logic [3:0]     r_step;
    logic [2:0]     r_oidx;

    b2b_pkg::t_word n_v [16];

    assign o_cmd_take    = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_empty       = (r_state != ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_comb begin
        logic [1:0] ia, ib, ic, id;
        b2b_pkg::t_word a, b, c, d, x, y;
        n_v = r_v;
        for (int g = 0; g < 4; g++) begin
            ia = 2'(g);
            ib = r_step[0] ? 2'(g + 1) : 2'(g);
            ic = r_step[0] ? 2'(g + 2) : 2'(g);
            id = r_step[0] ? 2'(g + 3) : 2'(g);
            a = r_v[{2'b00, ia}];
            b = r_v[{2'b01, ib}];
            c = r_v[{2'b10, ic}];
            d = r_v[{2'b11, id}];
            x = r_m[b2b_pkg::sigma(r_rmod, {r_step[0], 2'(g), 1'b0})];
            y = r_m[b2b_pkg::sigma(r_rmod, {r_step[0], 2'(g), 1'b1})];
            a = a + b + x;  d = b2b_pkg::rotr(d ^ a, 32);
            c = c + d;      b = b2b_pkg::rotr(b ^ c, 24);
            a = a + b + y;  d = b2b_pkg::rotr(d ^ a, 16);
            c = c + d;      b = b2b_pkg::rotr(b ^ c, 63);
            n_v[{2'b00, ia}] = a;
            n_v[{2'b01, ib}] = b;
            n_v[{2'b10, ic}] = c;
            n_v[{2'b11, id}] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int k = 0; k < 8; k++)
                r_h[k] <= b2b_pkg::iv_word(3'(k)) ^
                          ((k == 0) ? b2b_pkg::ParamWord : 64'd0);
            r_oidx  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        for (int k = 0; k < 8; k++)
                            r_v[k] <= r_h[k];
                        r_v[8]  <= b2b_pkg::iv_word(3'd0);
                        r_v[9]  <= b2b_pkg::iv_word(3'd1);
                        r_v[10] <= b2b_pkg::iv_word(3'd2);
                        r_v[11] <= b2b_pkg::iv_word(3'd3);
                        r_v[12] <= b2b_pkg::iv_word(3'd4) ^ i_cmd.len[63:0];
                        r_v[13] <= b2b_pkg::iv_word(3'd5) ^ i_cmd.len[127:64];
                        r_v[14] <= i_cmd.fin ? ~b2b_pkg::iv_word(3'd6) :
                                               b2b_pkg::iv_word(3'd6);
                        r_v[15] <= b2b_pkg::iv_word(3'd7);
                        r_m   <= i_blk;
                        r_fin <= i_cmd.fin;
                        r_rnd <= '0;
                        r_rmod <= '0;
                        r_step <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_v    <= n_v;
                    r_step <= r_step ^ 4'd1;
                    if (r_step[0]) begin
                        r_rnd  <= r_rnd + 1'b1;
                        r_rmod <= (r_rmod == 4'd9) ? 4'd0 : r_rmod + 4'd1;
                        if (32'(r_rnd) == ROUNDS - 1) begin
                            for (int k = 0; k < 8; k++)
                                r_h[k] <= r_h[k] ^ n_v[k] ^ n_v[k+8];
                            r_oidx  <= '0;
                            r_state <= r_fin ? ST_OUT : ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (i_pop) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int k = 0; k < 8; k++)
                                r_h[k] <= b2b_pkg::iv_word(3'(k)) ^
                                          ((k == 0) ? b2b_pkg::ParamWord : 64'd0);
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/blake2b_hash.sv
// BLAKE2b-512 top: front packer b2b_front, back compressor b2b_core. Uses b2b_pkg.
// Packing: the front takes one data word at a time and holds o_full until that word is packed;
// a full block moves to the back queue as an extra step. A block compression runs as
// column and diagonal half-round steps in the shared G-step unit.
// Reset: synchronous, active low; chain reloads IV, counter and fill clear.
module blake2b_hash #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_end_of_message,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic           cmd_valid;
    logic           cmd_take;
    b2b_pkg::t_cmd  cmd;
    b2b_pkg::t_word blk [b2b_pkg::BlkWds];

    b2b_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_data_word, .i_byte_count,
        .i_end_of_message, .o_cmd_valid(cmd_valid), .o_cmd(cmd), .o_blk(blk),
        .i_cmd_take(cmd_take)
    );

    b2b_core #(.ROUNDS(ROUNDS)) u_core (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .i_blk(blk),
        .o_cmd_take(cmd_take), .o_empty, .i_pop, .o_digest_word, .o_word_index,
        .o_last_word
    );

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("take without command");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last_word) |-> (o_word_index == 3'd7)) else $error("last index");
    a_pop_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_word) |=> (!o_empty &&
        o_word_index == $past(o_word_index) + 3'd1)) else $error("digest order");

endmodule
